[hdl/dssf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dssf_pkg;

    localparam int VALUE_W        = 28;
    localparam int START_W        = 3;
    localparam int COUNT_W        = 4;
    localparam int DP_W           = 3;
    localparam int BLINK_W        = 4;
    localparam int POS_W          = 6;
    localparam int DIGIT_POS_W    = 3;
    localparam int SEG_W          = 8;
    localparam int BCD_DIGITS     = 9;
    localparam int BCD_W          = BCD_DIGITS * 4;
    localparam int DABBLE_STAGES  = 4;
    localparam int BITS_PER_STAGE = VALUE_W / DABBLE_STAGES;
    // Digits from this index upward make up a magnitude of 10000 or more.
    localparam int LARGE_DIGIT    = 4;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    typedef struct packed {
        logic               neg;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic [DP_W-1:0]    dp;
        logic [BLINK_W-1:0] blink;
        logic               lz;
        logic               visible;
    } t_side;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        t_side            side;
    } t_job;

    function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'h0:    g = 8'h3F;
            4'h1:    g = 8'h06;
            4'h2:    g = 8'h5B;
            4'h3:    g = 8'h4F;
            4'h4:    g = 8'h66;
            4'h5:    g = 8'h6D;
            4'h6:    g = 8'h7D;
            4'h7:    g = 8'h07;
            4'h8:    g = 8'h7F;
            4'h9:    g = 8'h6F;
            4'hA:    g = 8'h77;
            4'hB:    g = 8'h7C;
            4'hC:    g = 8'h39;
            4'hD:    g = 8'h5E;
            4'hE:    g = 8'h79;
            4'hF:    g = 8'h71;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // One shift-and-add-three step of the binary to BCD conversion.
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (bcd[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = bcd[k*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage
`default_nettype wire

[hdl/decimal_seven_segment_formatter.sv]
// A request passes the input register, four BCD conversion stages, a preparation stage,
// the digit sequencer and the output register, the first loading at the accepting edge.
// Throughput: one result per cycle while the sink is ready; a request gives one result
// per digit of its digit count plus one for a minus sign, at most 9 at DIGITS = 8.
// Reset empties every pipeline stage, the sequencer and the output register.
`timescale 1ns / 1ps
`default_nettype none
module decimal_seven_segment_formatter #(
    parameter int DIGITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // value[27:0], start_position[30:28], digit_count[34:31], decimal_position[37:35],
    // blink_position[41:38], want_leading_zeros[42], blink_visible[43], zeros above
    input  wire logic [dssf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // digit_position[2:0], segments[10:3], zeros above
    output logic [dssf_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output logic                                     o_m_axis_tlast
);

    logic [dssf_pkg::VALUE_W-1:0]      value;
    dssf_pkg::t_side                   side_in;

    logic                              bcd_valid, bcd_ready;
    logic [dssf_pkg::BCD_W-1:0]        bcd;
    dssf_pkg::t_side                   bcd_side;

    logic                              job_valid, job_ready;
    dssf_pkg::t_job                    job;

    logic [dssf_pkg::DIGIT_POS_W-1:0]  pos;
    logic [dssf_pkg::SEG_W-1:0]        seg;

    always_comb begin
        value           = i_s_axis_tdata[27:0];
        side_in.neg     = 1'b0;
        side_in.start   = i_s_axis_tdata[30:28];
        side_in.count   = i_s_axis_tdata[34:31];
        side_in.dp      = i_s_axis_tdata[37:35];
        side_in.blink   = i_s_axis_tdata[41:38];
        side_in.lz      = i_s_axis_tdata[42];
        side_in.visible = i_s_axis_tdata[43];
    end

    dssf_bcd_pipe u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_value (value),
        .i_side  (side_in),
        .o_valid (bcd_valid),
        .i_ready (bcd_ready),
        .o_bcd   (bcd),
        .o_side  (bcd_side)
    );

    dssf_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bcd_valid),
        .o_ready (bcd_ready),
        .i_bcd   (bcd),
        .i_side  (bcd_side),
        .o_valid (job_valid),
        .i_ready (job_ready),
        .o_job   (job)
    );

    dssf_serial #(
        .DIGITS (DIGITS)
    ) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (job_valid),
        .o_ready (job_ready),
        .i_job   (job),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_pos   (pos),
        .o_seg   (seg),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {
        {(dssf_pkg::OUT_TDATA_W - dssf_pkg::SEG_W - dssf_pkg::DIGIT_POS_W){1'b0}}, seg, pos
    };

endmodule
`default_nettype wire

[hdl/dssf_bcd_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
module dssf_bcd_pipe (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [dssf_pkg::VALUE_W-1:0] i_value,
    input  wire dssf_pkg::t_side              i_side,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [dssf_pkg::BCD_W-1:0]        o_bcd,
    output dssf_pkg::t_side                   o_side
);

    localparam int NST = dssf_pkg::DABBLE_STAGES;

    logic                           r_vld0;
    logic [dssf_pkg::VALUE_W-1:0]   r_mag;
    dssf_pkg::t_side                r_side0;
    logic                           rdy0;

    logic                           r_vld  [NST];
    logic [dssf_pkg::BCD_W-1:0]     r_bcd  [NST];
    logic [dssf_pkg::VALUE_W-1:0]   r_bin  [NST];
    dssf_pkg::t_side                r_side [NST];

    logic                           rdy    [NST];
    logic                           src_vld  [NST];
    dssf_pkg::t_side                src_side [NST];
    logic [dssf_pkg::BCD_W-1:0]     n_bcd  [NST];
    logic [dssf_pkg::VALUE_W-1:0]   n_bin  [NST];

    logic                           neg;
    logic [dssf_pkg::VALUE_W-1:0]   n_mag;
    dssf_pkg::t_side                n_side0;

    always_comb begin
        neg             = i_value[dssf_pkg::VALUE_W-1];
        n_mag           = neg ? (~i_value + 1'b1) : i_value;
        n_side0         = i_side;
        n_side0.neg     = neg;
    end

    // A stage takes a new request when it is empty or its content moves on.
    always_comb begin
        for (int s = NST - 1; s >= 0; s--) begin
            if (s == NST - 1) begin
                rdy[s] = !r_vld[s] || i_ready;
            end else begin
                rdy[s] = !r_vld[s] || rdy[s+1];
            end
        end
        rdy0 = !r_vld0 || rdy[0];
    end

    always_comb begin
        for (int s = 0; s < NST; s++) begin
            logic [dssf_pkg::BCD_W-1:0]   bcd;
            logic [dssf_pkg::VALUE_W-1:0] bin;
            if (s == 0) begin
                bcd         = '0;
                bin         = r_mag;
                src_vld[s]  = r_vld0;
                src_side[s] = r_side0;
            end else begin
                bcd         = r_bcd[s-1];
                bin         = r_bin[s-1];
                src_vld[s]  = r_vld[s-1];
                src_side[s] = r_side[s-1];
            end
            for (int t = 0; t < dssf_pkg::BITS_PER_STAGE; t++) begin
                bcd = dssf_pkg::dabble_step(bcd, bin[dssf_pkg::VALUE_W-1]);
                bin = {bin[dssf_pkg::VALUE_W-2:0], 1'b0};
            end
            n_bcd[s] = bcd;
            n_bin[s] = bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            if (rdy0) begin
                r_vld0 <= i_valid;
            end
            for (int s = 0; s < NST; s++) begin
                if (rdy[s]) begin
                    r_vld[s] <= src_vld[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_mag   <= n_mag;
            r_side0 <= n_side0;
        end
        for (int s = 0; s < NST; s++) begin
            if (rdy[s]) begin
                r_bcd[s]  <= n_bcd[s];
                r_bin[s]  <= n_bin[s];
                r_side[s] <= src_side[s];
            end
        end
    end

    assign o_ready = rdy0;
    assign o_valid = r_vld[NST-1];
    assign o_bcd   = r_bcd[NST-1];
    assign o_side  = r_side[NST-1];

endmodule
`default_nettype wire

[hdl/dssf_prep.sv]
`timescale 1ns / 1ps
`default_nettype none
module dssf_prep (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [dssf_pkg::BCD_W-1:0] i_bcd,
    input  wire dssf_pkg::t_side           i_side,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output dssf_pkg::t_job                 o_job
);

    logic                         r_vld;
    dssf_pkg::t_job               r_job;
    dssf_pkg::t_job               n_job;
    logic                         upper_nz;
    logic                         big_neg;
    logic                         high_nz;

    always_comb begin
        upper_nz = 1'b0;
        for (int k = dssf_pkg::LARGE_DIGIT; k < dssf_pkg::BCD_DIGITS; k++) begin
            upper_nz = upper_nz | (|i_bcd[k*4 +: 4]);
        end
        // A large negative magnitude keeps its low four digits and loses a field digit.
        big_neg   = i_side.neg && upper_nz;
        n_job.bcd = i_bcd;
        if (big_neg) begin
            n_job.bcd[dssf_pkg::BCD_W-1:dssf_pkg::LARGE_DIGIT*4] = '0;
        end
        n_job.side = i_side;
        if (big_neg && (i_side.count != '0)) begin
            n_job.side.count = i_side.count - 1'b1;
        end
        // Below one unit of the scale, leading zeros are forced on, so every digit is shown.
        high_nz = 1'b0;
        for (int k = 0; k < dssf_pkg::BCD_DIGITS; k++) begin
            if (k >= int'(i_side.dp)) begin
                high_nz = high_nz | (|n_job.bcd[k*4 +: 4]);
            end
        end
        n_job.side.lz = i_side.lz || !high_nz;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_vld;
    assign o_job   = r_job;

endmodule
`default_nettype wire

[hdl/dssf_serial.sv]
`timescale 1ns / 1ps
`default_nettype none
module dssf_serial #(
    parameter int DIGITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire dssf_pkg::t_job                    i_job,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [dssf_pkg::DIGIT_POS_W-1:0]       o_pos,
    output logic [dssf_pkg::SEG_W-1:0]             o_seg,
    output logic                                   o_last
);

    localparam int CNT_IN_MAX = (1 << dssf_pkg::COUNT_W) - 1;
    localparam int CNT_MAX    = (DIGITS < CNT_IN_MAX) ? DIGITS : CNT_IN_MAX;
    localparam int LW         = (CNT_MAX < 2) ? 1 : $clog2(CNT_MAX + 1);

    logic                              r_busy, n_busy;
    logic                              r_neg_pend, n_neg_pend;
    logic [LW-1:0]                     r_left, n_left;
    logic [LW-1:0]                     r_i, n_i;
    logic [dssf_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [dssf_pkg::BCD_W-1:0]        r_bcd, n_bcd;
    logic [dssf_pkg::DP_W-1:0]         r_dp, n_dp;
    logic [dssf_pkg::BLINK_W-1:0]      r_blink, n_blink;
    logic                              r_lz, n_lz;
    logic                              r_vis, n_vis;

    logic                              r_ovld;
    logic [dssf_pkg::DIGIT_POS_W-1:0]  r_opos;
    logic [dssf_pkg::SEG_W-1:0]        r_oseg;
    logic                              r_olast;

    logic                              emit;
    logic                              load;
    logic [dssf_pkg::DIGIT_POS_W-1:0]  e_pos;
    logic [dssf_pkg::SEG_W-1:0]        e_seg;
    logic                              e_last;
    logic [dssf_pkg::SEG_W-1:0]        dot;
    logic [dssf_pkg::POS_W-1:0]        blink_ext;
    logic [LW-1:0]                     cnt_c;

    always_comb begin
        emit      = r_busy && (!r_ovld || i_ready);
        blink_ext = {{(dssf_pkg::POS_W - dssf_pkg::BLINK_W){r_blink[dssf_pkg::BLINK_W-1]}},
                     r_blink};
        dot       = (8'(r_i) == 8'(r_dp)) ? dssf_pkg::SEG_DOT : dssf_pkg::SEG_BLANK;

        if (r_neg_pend) begin
            e_pos  = '0;
            e_seg  = dssf_pkg::SEG_MINUS;
            e_last = (r_left == '0);
        end else begin
            e_pos  = r_pos[dssf_pkg::DIGIT_POS_W-1:0];
            e_last = (r_left == LW'(1));
            if ((r_pos == blink_ext) && !r_vis) begin
                e_seg = dssf_pkg::SEG_BLANK;
            end else if (|r_bcd) begin
                e_seg = dssf_pkg::glyph(r_bcd[3:0]) | dot;
            end else if (r_lz || (r_i == '0)) begin
                e_seg = dssf_pkg::glyph(4'd0) | dot;
            end else begin
                e_seg = dssf_pkg::SEG_BLANK;
            end
        end

        o_ready = !r_busy || (emit && e_last);
        load    = i_valid && o_ready;

        if (int'(i_job.side.count) > CNT_MAX) begin
            cnt_c = LW'(CNT_MAX);
        end else begin
            cnt_c = LW'(i_job.side.count);
        end

        n_busy     = r_busy;
        n_neg_pend = r_neg_pend;
        n_left     = r_left;
        n_i        = r_i;
        n_pos      = r_pos;
        n_bcd      = r_bcd;
        n_dp       = r_dp;
        n_blink    = r_blink;
        n_lz       = r_lz;
        n_vis      = r_vis;

        if (emit) begin
            if (r_neg_pend) begin
                n_neg_pend = 1'b0;
            end else begin
                // The digit is used up even when it is blanked for blinking.
                n_left = r_left - 1'b1;
                n_i    = r_i + 1'b1;
                n_pos  = r_pos - 1'b1;
                n_bcd  = {4'd0, r_bcd[dssf_pkg::BCD_W-1:4]};
            end
            if (e_last) begin
                n_busy = 1'b0;
            end
        end

        if (load) begin
            n_busy     = i_job.side.neg || (cnt_c != '0);
            n_neg_pend = i_job.side.neg;
            n_left     = cnt_c;
            n_i        = '0;
            n_pos      = dssf_pkg::POS_W'(i_job.side.start);
            n_bcd      = i_job.bcd;
            n_dp       = i_job.side.dp;
            n_blink    = i_job.side.blink;
            n_lz       = i_job.side.lz;
            n_vis      = i_job.side.visible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_neg_pend <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_neg_pend <= n_neg_pend;
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_i     <= n_i;
        r_pos   <= n_pos;
        r_bcd   <= n_bcd;
        r_dp    <= n_dp;
        r_blink <= n_blink;
        r_lz    <= n_lz;
        r_vis   <= n_vis;
        if (emit) begin
            r_opos  <= e_pos;
            r_oseg  <= e_seg;
            r_olast <= e_last;
        end
    end

    assign o_valid = r_ovld;
    assign o_pos   = r_opos;
    assign o_seg   = r_oseg;
    assign o_last  = r_olast;

endmodule
`default_nettype wire

[hdl/dssf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module dssf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_s_axis_tready,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [dssf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                            o_m_axis_tlast
);

    // A result stalled by the sink is still offered in the next cycle.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("stalled result withdrawn");

    // Reset leaves no result on offer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

    // The minus sign always goes to display position 0.
    a_minus_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[10:3] == dssf_pkg::SEG_MINUS))
        |-> (o_m_axis_tdata[2:0] == 3'd0))
        else $error("minus sign away from position 0");

    // The dot is only ever lit together with a digit glyph.
    a_dot_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[10]) |-> (o_m_axis_tdata[9:3] != 7'd0))
        else $error("dot on a blank digit");

    // Handshake outputs are always driven, and an offered result is fully defined.
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_s_axis_tready, o_m_axis_tvalid}) &&
        (!o_m_axis_tvalid || !$isunknown({o_m_axis_tdata, o_m_axis_tlast})))
        else $error("unknown value on an output");

endmodule

bind decimal_seven_segment_formatter dssf_checker u_dssf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire
